FILE: hdl/hbp_pkg.sv
// Package for the hybrid branch predictor with target buffer.
// Holds table sizes, counter constants, mode and register codes, the buffer row type
// and small helper functions. No dependencies.
package hbp_pkg;

    // Table geometry
    localparam int BIM_W    = 12;
    localparam int GSH_W    = 12;
    localparam int HIST_W   = 8;
    localparam int CHO_W    = 10;
    localparam int BTB_SETS = 64;
    localparam int BTB_WAYS = 4;

    localparam int BIM_DEPTH = 1 << BIM_W;
    localparam int GSH_DEPTH = 1 << GSH_W;
    localparam int CHO_DEPTH = 1 << CHO_W;

    localparam int SET_BITS = $clog2(BTB_SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = 30 - SET_BITS;
    localparam int AGE_W    = (BTB_WAYS > 1) ? $clog2(BTB_WAYS) : 1;
    localparam int WAY_W    = AGE_W;

    // Sweep width of the post-reset clearing pass
    localparam int CLR_A = (BIM_W > GSH_W) ? BIM_W : GSH_W;
    localparam int CLR_B = (CHO_W > SET_W) ? CHO_W : SET_W;
    localparam int CLR_W = (CLR_A > CLR_B) ? CLR_A : CLR_B;

    // Two-bit saturating counters
    localparam int          CTR_W     = 2;
    localparam logic [1:0]  CTR_MAX   = 2'd3;
    localparam logic [1:0]  BIM_RESET = 2'd2;
    localparam logic [1:0]  GSH_RESET = 2'd2;
    localparam logic [1:0]  CHO_RESET = 2'd1;

    // Mode codes; the spare code behaves as hybrid
    localparam int          MODE_W       = 2;
    localparam logic [1:0]  MODE_BIMODAL = 2'd0;
    localparam logic [1:0]  MODE_GSHARE  = 2'd1;
    localparam logic [1:0]  MODE_HYBRID  = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 1'b0,
        CFG_BTB_ENABLE = 1'b1
    } t_cfg_idx;

    // One set of the target buffer
    typedef struct packed {
        logic [BTB_WAYS-1:0]            valid;
        logic [BTB_WAYS-1:0][TAG_W-1:0] tag;
        logic [BTB_WAYS-1:0][AGE_W-1:0] age;
    } t_btb_row;

    // Step a saturating counter up or down
    function automatic logic [CTR_W-1:0] sat_step(input logic [CTR_W-1:0] c, input logic up);
        logic [CTR_W-1:0] r;
        if (up) begin
            r = (c == CTR_MAX) ? c : c + 1'b1;
        end else begin
            r = (c == '0) ? c : c - 1'b1;
        end
        return r;
    endfunction

    // Align the history with the gshare index: left shift when the index is wider,
    // right shift when the history is wider
    function automatic logic [GSH_W-1:0] gsh_hist_bits(input logic [HIST_W-1:0] h);
        logic [HIST_W+GSH_W-1:0] wide;
        wide = {h, {GSH_W{1'b0}}};
        return wide[HIST_W +: GSH_W];
    endfunction

    // Buffer row after reset: all invalid, age equal to way number
    function automatic t_btb_row btb_row_reset();
        t_btb_row r;
        r = '0;
        for (int w = 0; w < BTB_WAYS; w++) begin
            r.age[w] = AGE_W'(w);
        end
        return r;
    endfunction

endpackage

FILE: hdl/hbp_in_if.sv
// Input channel of the branch predictor: one resolved branch per item.
// Valid/ready handshake; no dependencies.
interface hbp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        taken;

    modport source (output valid, output address, output taken, input ready);
    modport sink   (input valid, input address, input taken, output ready);
endinterface

FILE: hdl/hbp_out_if.sv
// Output channel of the branch predictor: one prediction report per item.
// Valid/ready handshake; no dependencies.
interface hbp_out_if;
    logic        valid;
    logic        ready;
    logic        predicted_taken;
    logic        btb_hit;
    logic        used_gshare;
    logic        mispredicted;
    logic [31:0] branch_count;
    logic [31:0] mispredict_count;

    modport source (output valid, output predicted_taken, output btb_hit, output used_gshare,
                    output mispredicted, output branch_count, output mispredict_count,
                    input ready);
    modport sink   (input valid, input predicted_taken, input btb_hit, input used_gshare,
                    input mispredicted, input branch_count, input mispredict_count,
                    output ready);
endinterface

FILE: hdl/hybrid_branch_predictor_btb_core.sv
// Hybrid bimodal/gshare branch predictor with chooser and set-associative LRU target buffer.
// Depends on hbp_pkg, hbp_in_if and hbp_out_if.
//
// Takes one branch item per clock while the result register is free or being taken. An
// accepted item has its table reads registered at acceptance; stage 1 then compares tags
// and forms the prediction and, when it advances, writes the counters, chooser and buffer
// row back and loads the result register. The last write to each table is held in a bypass
// register so back-to-back branches to the same entry see fresh data. After reset the
// tables are swept to their reset values, one entry per cycle, during which no item is
// accepted; configuration writes are taken at any time.
module hybrid_branch_predictor_btb_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hbp_in_if.sink                         i_in,
    hbp_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [hbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration
    logic [hbp_pkg::MODE_W-1:0] r_mode;
    logic                       r_btb_en;

    // Clearing pass
    logic                      r_clearing;
    logic [hbp_pkg::CLR_W-1:0] r_clr;
    logic                      clr_bim, clr_gsh, clr_cho, clr_btb;

    // Architectural registers
    logic [hbp_pkg::HIST_W-1:0] r_hist, n_hist;
    logic [31:0]                r_br_cnt, n_br_cnt;
    logic [31:0]                r_miss_cnt, n_miss_cnt;

    // Stage 1 item
    logic                       r_s1_valid;
    logic                       r_s1_taken;
    logic [hbp_pkg::BIM_W-1:0]  r_s1_bi;
    logic [hbp_pkg::GSH_W-1:0]  r_s1_gi;
    logic [hbp_pkg::CHO_W-1:0]  r_s1_ci;
    logic [hbp_pkg::SET_W-1:0]  r_s1_set;
    logic [hbp_pkg::TAG_W-1:0]  r_s1_tag;

    // Memories and read data
    logic [hbp_pkg::CTR_W-1:0] r_bim_mem [hbp_pkg::BIM_DEPTH];
    logic [hbp_pkg::CTR_W-1:0] r_gsh_mem [hbp_pkg::GSH_DEPTH];
    logic [hbp_pkg::CTR_W-1:0] r_cho_mem [hbp_pkg::CHO_DEPTH];
    hbp_pkg::t_btb_row         r_btb_mem [hbp_pkg::BTB_SETS];
    logic [hbp_pkg::CTR_W-1:0] r_bim_rd, r_gsh_rd, r_cho_rd;
    hbp_pkg::t_btb_row         r_btb_rd;

    // Bypass of the last write to each table
    logic                      r_fw_bim_v, r_fw_gsh_v, r_fw_cho_v, r_fw_btb_v;
    logic [hbp_pkg::BIM_W-1:0] r_fw_bim_idx;
    logic [hbp_pkg::GSH_W-1:0] r_fw_gsh_idx;
    logic [hbp_pkg::CHO_W-1:0] r_fw_cho_idx;
    logic [hbp_pkg::SET_W-1:0] r_fw_btb_idx;
    logic [hbp_pkg::CTR_W-1:0] r_fw_bim_d, r_fw_gsh_d, r_fw_cho_d;
    hbp_pkg::t_btb_row         r_fw_btb_d;

    // Result register
    logic        r_out_valid;
    logic        r_out_pred, r_out_hit, r_out_used_g, r_out_miss;
    logic [31:0] r_out_br, r_out_miss_cnt;

    // Handshake
    logic in_accept, s1_adv, s1_fire;

    // Input-side indices
    logic [hbp_pkg::BIM_W-1:0] in_bi;
    logic [hbp_pkg::GSH_W-1:0] in_gi;
    logic [hbp_pkg::CHO_W-1:0] in_ci;
    logic [hbp_pkg::SET_W-1:0] in_set_raw, in_set;
    logic [hbp_pkg::TAG_W-1:0] in_tag;

    // Stage 1 logic
    logic [hbp_pkg::CTR_W-1:0] bim_cur, gsh_cur, cho_cur;
    logic [hbp_pkg::CTR_W-1:0] bim_new, gsh_new, cho_new;
    hbp_pkg::t_btb_row         row_cur, row_new;
    logic [hbp_pkg::BTB_WAYS-1:0] hit_vec;
    logic                      tag_hit, inv_any, touch;
    logic [hbp_pkg::WAY_W-1:0] hit_way, inv_way, ref_way, repl_way;
    logic [hbp_pkg::AGE_W-1:0] ref_age;
    logic [hbp_pkg::AGE_W:0]   age_inc;
    logic                      hit, bp, gp, pred, use_g;
    logic                      bim_we, gsh_we, cho_we, hist_sh, btb_we;

    assign s1_adv    = !r_out_valid || o_out.ready;
    assign s1_fire   = r_s1_valid && s1_adv;
    assign i_in.ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_accept = i_in.valid && i_in.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= hbp_pkg::MODE_BIMODAL;
            r_btb_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (hbp_pkg::t_cfg_idx'(i_cfg_index))
                hbp_pkg::CFG_MODE:       r_mode   <= i_cfg_data[hbp_pkg::MODE_W-1:0];
                hbp_pkg::CFG_BTB_ENABLE: r_btb_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sweep every table to its reset value after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign clr_bim = r_clearing &&
                     ({1'b0, r_clr} < (hbp_pkg::CLR_W+1)'(hbp_pkg::BIM_DEPTH));
    assign clr_gsh = r_clearing &&
                     ({1'b0, r_clr} < (hbp_pkg::CLR_W+1)'(hbp_pkg::GSH_DEPTH));
    assign clr_cho = r_clearing &&
                     ({1'b0, r_clr} < (hbp_pkg::CLR_W+1)'(hbp_pkg::CHO_DEPTH));
    assign clr_btb = r_clearing &&
                     ({1'b0, r_clr} < (hbp_pkg::CLR_W+1)'(hbp_pkg::BTB_SETS));

    // Input-side indices; gshare uses the history left by the item now finishing
    always_comb begin
        in_bi      = i_in.address[2 +: hbp_pkg::BIM_W];
        in_ci      = i_in.address[2 +: hbp_pkg::CHO_W];
        in_gi      = i_in.address[2 +: hbp_pkg::GSH_W] ^ hbp_pkg::gsh_hist_bits(n_hist);
        in_set_raw = i_in.address[2 +: hbp_pkg::SET_W];
        in_set     = ({1'b0, in_set_raw} >= (hbp_pkg::SET_W+1)'(hbp_pkg::BTB_SETS)) ?
                     in_set_raw - hbp_pkg::SET_W'(hbp_pkg::BTB_SETS) : in_set_raw;
        in_tag     = i_in.address[31 -: hbp_pkg::TAG_W];
    end

    // Stage 1 input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_taken <= i_in.taken;
            r_s1_bi    <= in_bi;
            r_s1_gi    <= in_gi;
            r_s1_ci    <= in_ci;
            r_s1_set   <= in_set;
            r_s1_tag   <= in_tag;
        end
    end

    // Bimodal counter table
    always_ff @(posedge i_clk) begin
        if (clr_bim) begin
            r_bim_mem[r_clr[hbp_pkg::BIM_W-1:0]] <= hbp_pkg::BIM_RESET;
        end else if (s1_fire && bim_we) begin
            r_bim_mem[r_s1_bi] <= bim_new;
        end
        if (in_accept) begin
            r_bim_rd <= r_bim_mem[in_bi];
        end
    end

    // Gshare counter table
    always_ff @(posedge i_clk) begin
        if (clr_gsh) begin
            r_gsh_mem[r_clr[hbp_pkg::GSH_W-1:0]] <= hbp_pkg::GSH_RESET;
        end else if (s1_fire && gsh_we) begin
            r_gsh_mem[r_s1_gi] <= gsh_new;
        end
        if (in_accept) begin
            r_gsh_rd <= r_gsh_mem[in_gi];
        end
    end

    // Chooser table
    always_ff @(posedge i_clk) begin
        if (clr_cho) begin
            r_cho_mem[r_clr[hbp_pkg::CHO_W-1:0]] <= hbp_pkg::CHO_RESET;
        end else if (s1_fire && cho_we) begin
            r_cho_mem[r_s1_ci] <= cho_new;
        end
        if (in_accept) begin
            r_cho_rd <= r_cho_mem[in_ci];
        end
    end

    // Target buffer, one row per set
    always_ff @(posedge i_clk) begin
        if (clr_btb) begin
            r_btb_mem[r_clr[hbp_pkg::SET_W-1:0]] <= hbp_pkg::btb_row_reset();
        end else if (s1_fire && btb_we) begin
            r_btb_mem[r_s1_set] <= row_new;
        end
        if (in_accept) begin
            r_btb_rd <= r_btb_mem[in_set];
        end
    end

    // Hold the last write to each table for the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_bim_v <= 1'b0;
            r_fw_gsh_v <= 1'b0;
            r_fw_cho_v <= 1'b0;
            r_fw_btb_v <= 1'b0;
        end else if (s1_fire) begin
            if (bim_we) r_fw_bim_v <= 1'b1;
            if (gsh_we) r_fw_gsh_v <= 1'b1;
            if (cho_we) r_fw_cho_v <= 1'b1;
            if (btb_we) r_fw_btb_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (bim_we) begin
                r_fw_bim_idx <= r_s1_bi;
                r_fw_bim_d   <= bim_new;
            end
            if (gsh_we) begin
                r_fw_gsh_idx <= r_s1_gi;
                r_fw_gsh_d   <= gsh_new;
            end
            if (cho_we) begin
                r_fw_cho_idx <= r_s1_ci;
                r_fw_cho_d   <= cho_new;
            end
            if (btb_we) begin
                r_fw_btb_idx <= r_s1_set;
                r_fw_btb_d   <= row_new;
            end
        end
    end

    // Select fresh table data
    always_comb begin
        bim_cur = (r_fw_bim_v && r_fw_bim_idx == r_s1_bi)  ? r_fw_bim_d : r_bim_rd;
        gsh_cur = (r_fw_gsh_v && r_fw_gsh_idx == r_s1_gi)  ? r_fw_gsh_d : r_gsh_rd;
        cho_cur = (r_fw_cho_v && r_fw_cho_idx == r_s1_ci)  ? r_fw_cho_d : r_cho_rd;
        row_cur = (r_fw_btb_v && r_fw_btb_idx == r_s1_set) ? r_fw_btb_d : r_btb_rd;
    end

    // Tag compare, first invalid way
    always_comb begin
        hit_way = '0;
        inv_way = '0;
        for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
            hit_vec[w] = row_cur.valid[w] && (row_cur.tag[w] == r_s1_tag);
        end
        for (int w = hbp_pkg::BTB_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) hit_way = hbp_pkg::WAY_W'(w);
            if (!row_cur.valid[w]) inv_way = hbp_pkg::WAY_W'(w);
        end
        tag_hit = |hit_vec;
        inv_any = !(&row_cur.valid);
    end

    // LRU update and allocation
    always_comb begin
        touch    = tag_hit || inv_any;
        ref_way  = tag_hit ? hit_way : inv_way;
        ref_age  = row_cur.age[ref_way];
        row_new  = row_cur;
        repl_way = ref_way;
        age_inc  = '0;
        if (touch) begin
            for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
                if (row_cur.age[w] < ref_age) begin
                    row_new.age[w] = row_cur.age[w] + 1'b1;
                end
            end
            row_new.age[ref_way] = '0;
        end else begin
            // Age every way; the one wrapping to zero is replaced
            for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
                age_inc = {1'b0, row_cur.age[w]} + 1'b1;
                if (age_inc == (hbp_pkg::AGE_W+1)'(hbp_pkg::BTB_WAYS)) begin
                    row_new.age[w] = '0;
                end else begin
                    row_new.age[w] = age_inc[hbp_pkg::AGE_W-1:0];
                end
                if (row_new.age[w] == '0) repl_way = hbp_pkg::WAY_W'(w);
            end
        end
        if (!tag_hit) begin
            row_new.valid[repl_way] = 1'b1;
            row_new.tag[repl_way]   = r_s1_tag;
        end
        btb_we = r_btb_en;
    end

    // Prediction and counter updates
    always_comb begin
        hit     = r_btb_en ? tag_hit : 1'b1;
        bp      = hit && bim_cur[1];
        gp      = hit && gsh_cur[1];
        bim_new = hbp_pkg::sat_step(bim_cur, r_s1_taken);
        gsh_new = hbp_pkg::sat_step(gsh_cur, r_s1_taken);
        cho_new = hbp_pkg::sat_step(cho_cur, gp == r_s1_taken);
        bim_we  = 1'b0;
        gsh_we  = 1'b0;
        cho_we  = 1'b0;
        hist_sh = 1'b0;
        case (r_mode)
            hbp_pkg::MODE_BIMODAL: begin
                use_g  = 1'b0;
                pred   = bp;
                bim_we = hit;
            end
            hbp_pkg::MODE_GSHARE: begin
                use_g   = 1'b1;
                pred    = gp;
                gsh_we  = hit;
                hist_sh = hit;
            end
            default: begin
                use_g   = cho_cur[1];
                pred    = use_g ? gp : bp;
                bim_we  = hit && !use_g;
                gsh_we  = hit && use_g;
                hist_sh = 1'b1;
                cho_we  = (bp == r_s1_taken) != (gp == r_s1_taken);
            end
        endcase
    end

    // Next history and running counts
    always_comb begin
        n_hist = r_hist;
        if (r_s1_valid && hist_sh) begin
            n_hist = (r_hist >> 1) |
                     (hbp_pkg::HIST_W'(r_s1_taken) << (hbp_pkg::HIST_W - 1));
        end
        n_br_cnt   = r_br_cnt + 32'd1;
        n_miss_cnt = r_miss_cnt + 32'(pred != r_s1_taken);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_br_cnt   <= '0;
            r_miss_cnt <= '0;
        end else if (s1_fire) begin
            r_hist     <= n_hist;
            r_br_cnt   <= n_br_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_pred     <= pred;
            r_out_hit      <= r_btb_en && tag_hit;
            r_out_used_g   <= use_g;
            r_out_miss     <= pred != r_s1_taken;
            r_out_br       <= n_br_cnt;
            r_out_miss_cnt <= n_miss_cnt;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.predicted_taken  = r_out_pred;
    assign o_out.btb_hit          = r_out_hit;
    assign o_out.used_gshare      = r_out_used_g;
    assign o_out.mispredicted     = r_out_miss;
    assign o_out.branch_count     = r_out_br;
    assign o_out.mispredict_count = r_out_miss_cnt;

endmodule

FILE: tb/tb_hybrid_branch_predictor_btb_core.sv
// Self-checking testbench for hybrid_branch_predictor_btb_core.
// Depends on hbp_pkg, hbp_in_if, hbp_out_if and the core; carries its own predictor
// and target-buffer model and checks every result against it.
module tb_hybrid_branch_predictor_btb_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] TAKEN_MIN   = 2'd2;
    localparam logic [1:0] CTR_FLOOR   = 2'd0;
    localparam int         HOT_COUNT   = 32;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         HOLD_AT     = 120;
    localparam int         HOLD_LEN    = 100;
    localparam int         CALM_FROM   = 260;
    localparam int         CALM_TO     = 340;

    typedef struct {
        logic [31:0] addr;
        logic        taken;
    } t_branch;

    typedef struct {
        logic        pred;
        logic        hit;
        logic        used_g;
        logic        misp;
        logic [31:0] n_br;
        logic [31:0] n_mis;
    } t_prediction;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [hbp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hbp_pkg::CFG_DATA_W-1:0] cfg_data;

    hbp_in_if  br_if ();
    hbp_out_if res_if ();

    hybrid_branch_predictor_btb_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (br_if),
        .o_out       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state
    logic [1:0]                 bim_ctr [hbp_pkg::BIM_DEPTH];
    logic [1:0]                 gsh_ctr [hbp_pkg::GSH_DEPTH];
    logic [1:0]                 cho_ctr [hbp_pkg::CHO_DEPTH];
    logic [hbp_pkg::HIST_W-1:0] ghist;
    logic                       tgt_valid [hbp_pkg::BTB_SETS][hbp_pkg::BTB_WAYS];
    logic [hbp_pkg::TAG_W-1:0]  tgt_tag [hbp_pkg::BTB_SETS][hbp_pkg::BTB_WAYS];
    logic [hbp_pkg::AGE_W-1:0]  tgt_age [hbp_pkg::BTB_SETS][hbp_pkg::BTB_WAYS];
    logic [31:0]                n_branches;
    logic [31:0]                n_misses;
    logic [1:0]                 cur_mode;
    logic                       btb_on;

    // Stimulus and scoreboard
    t_branch     branches_pending [$];
    t_prediction predictions_due [$];
    logic [31:0] hot_addr [HOT_COUNT];
    logic        hot_bias [HOT_COUNT];

    int   n_queued;
    int   n_in;
    int   n_checked;
    int   n_hits;
    int   n_misp;
    int   n_err;
    int   cycles;
    int   rx_hold;
    logic rx_hold_used;
    logic in_took;
    logic rst_done;
    logic calm;

    assign calm = (n_in >= CALM_FROM) && (n_in < CALM_TO);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Step a two-bit saturating counter
    function automatic logic [1:0] ctr_bump(input logic [1:0] c, input logic up);
        if (up) begin
            return (c == hbp_pkg::CTR_MAX) ? c : c + 2'd1;
        end
        return (c == CTR_FLOOR) ? c : c - 2'd1;
    endfunction

    // Make a way most recently used; younger ways age by one
    function automatic void age_ways(input int s, input int way);
        logic [hbp_pkg::AGE_W-1:0] ref_age;
        ref_age = tgt_age[s][way];
        for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
            if (tgt_age[s][w] < ref_age) begin
                tgt_age[s][w] = tgt_age[s][w] + 1'b1;
            end
        end
        tgt_age[s][way] = '0;
    endfunction

    // Look up the target buffer; allocate on a miss
    function automatic logic lookup_target(input logic [31:0] addr);
        int                        s;
        int                        way;
        logic [hbp_pkg::TAG_W-1:0] tg;
        s   = int'((addr >> 2) & ((32'd1 << hbp_pkg::SET_BITS) - 1)) % hbp_pkg::BTB_SETS;
        tg  = hbp_pkg::TAG_W'(addr >> (hbp_pkg::SET_BITS + 2));
        way = -1;
        for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
            if (tgt_valid[s][w] && tgt_tag[s][w] == tg) begin
                age_ways(s, w);
                return 1'b1;
            end
        end
        for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
            if (!tgt_valid[s][w] && way < 0) begin
                way = w;
            end
        end
        if (way >= 0) begin
            age_ways(s, way);
        end else begin
            for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
                tgt_age[s][w] = hbp_pkg::AGE_W'((int'(tgt_age[s][w]) + 1) %
                                                hbp_pkg::BTB_WAYS);
                if (tgt_age[s][w] == '0) begin
                    way = w;
                end
            end
        end
        tgt_tag[s][way]   = tg;
        tgt_valid[s][way] = 1'b1;
        return 1'b0;
    endfunction

    // Work out the report for one resolved branch and update the tables
    task automatic predict_branch(input t_branch b, output t_prediction r);
        logic [31:0] pc;
        int          bi;
        int          gi;
        int          ci;
        logic        hit;
        logic        pred;
        logic        use_g;
        logic        bp;
        logic        gp;
        pc  = b.addr >> 2;
        bi  = int'(pc[hbp_pkg::BIM_W-1:0]);
        gi  = int'(((32'(ghist) << (hbp_pkg::GSH_W - hbp_pkg::HIST_W)) ^ pc) &
                   ((32'd1 << hbp_pkg::GSH_W) - 1));
        ci  = int'(pc[hbp_pkg::CHO_W-1:0]);
        hit = 1'b1;
        if (btb_on) begin
            hit = lookup_target(b.addr);
        end
        case (cur_mode)
            hbp_pkg::MODE_BIMODAL: begin
                use_g = 1'b0;
                pred  = hit && (bim_ctr[bi] >= TAKEN_MIN);
                if (hit) begin
                    bim_ctr[bi] = ctr_bump(bim_ctr[bi], b.taken);
                end
            end
            hbp_pkg::MODE_GSHARE: begin
                use_g = 1'b1;
                pred  = hit && (gsh_ctr[gi] >= TAKEN_MIN);
                if (hit) begin
                    gsh_ctr[gi] = ctr_bump(gsh_ctr[gi], b.taken);
                    ghist       = {b.taken, ghist[hbp_pkg::HIST_W-1:1]};
                end
            end
            default: begin
                // Hybrid, and the spare code that behaves as hybrid
                bp    = hit && (bim_ctr[bi] >= TAKEN_MIN);
                gp    = hit && (gsh_ctr[gi] >= TAKEN_MIN);
                use_g = cho_ctr[ci] >= TAKEN_MIN;
                pred  = use_g ? gp : bp;
                if (hit) begin
                    if (use_g) begin
                        gsh_ctr[gi] = ctr_bump(gsh_ctr[gi], b.taken);
                    end else begin
                        bim_ctr[bi] = ctr_bump(bim_ctr[bi], b.taken);
                    end
                end
                ghist = {b.taken, ghist[hbp_pkg::HIST_W-1:1]};
                if ((bp == b.taken) != (gp == b.taken)) begin
                    cho_ctr[ci] = ctr_bump(cho_ctr[ci], gp == b.taken);
                end
            end
        endcase
        n_branches = n_branches + 1;
        if (pred != b.taken) begin
            n_misses = n_misses + 1;
        end
        r.pred   = pred;
        r.hit    = btb_on && hit;
        r.used_g = use_g;
        r.misp   = pred != b.taken;
        r.n_br   = n_branches;
        r.n_mis  = n_misses;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        n_err++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      n_checked, name, got, want));
        end
    endtask

    // Monitor: check results against the oldest prediction, then predict accepted items
    always @(posedge i_clk) begin
        t_prediction want;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("hybrid_branch_predictor_btb_core verification failed");
            $finish;
        end else begin
            in_took <= i_rst_n && br_if.valid && br_if.ready;
            if (i_rst_n && res_if.valid === 1'b1 && res_if.ready) begin
                if (predictions_due.size() == 0) begin
                    report_mismatch("result with no branch outstanding");
                end else begin
                    want = predictions_due.pop_front();
                    check_field("predicted_taken", 32'(res_if.predicted_taken),
                                32'(want.pred));
                    check_field("btb_hit", 32'(res_if.btb_hit), 32'(want.hit));
                    check_field("used_gshare", 32'(res_if.used_gshare), 32'(want.used_g));
                    check_field("mispredicted", 32'(res_if.mispredicted), 32'(want.misp));
                    check_field("branch_count", res_if.branch_count, want.n_br);
                    check_field("mispredict_count", res_if.mispredict_count, want.n_mis);
                    n_checked++;
                    n_hits += int'(want.hit);
                    n_misp += int'(want.misp);
                end
            end
            if (i_rst_n && br_if.valid && br_if.ready) begin
                predict_branch('{addr: br_if.address, taken: br_if.taken}, want);
                predictions_due.push_back(want);
                n_in <= n_in + 1;
            end
        end
    end

    // Driver: offer the next pending item, idling now and then
    always @(negedge i_clk) begin
        t_branch nb;
        if (!br_if.valid || in_took) begin
            if (rst_done && branches_pending.size() > 0 &&
                (calm || $urandom_range(99) >= 13)) begin
                nb = branches_pending.pop_front();
                br_if.valid   <= 1'b1;
                br_if.address <= nb.addr;
                br_if.taken   <= nb.taken;
            end else begin
                br_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off to back the core up
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            res_if.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end else if (!rx_hold_used && n_in >= HOLD_AT) begin
            res_if.ready <= 1'b0;
            rx_hold      <= HOLD_LEN - 1;
            rx_hold_used <= 1'b1;
        end else if (calm) begin
            res_if.ready <= 1'b1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= 13);
        end
    end

    task automatic cfg_write(input hbp_pkg::t_cfg_idx idx,
                             input logic [hbp_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            hbp_pkg::CFG_MODE:       cur_mode = val;
            hbp_pkg::CFG_BTB_ENABLE: btb_on   = val[0];
            default: ;
        endcase
    endtask

    task automatic queue_branch(input logic [31:0] addr, input logic taken);
        branches_pending.push_back('{addr: addr, taken: taken});
        n_queued++;
    endtask

    // Mostly hot branches with a usual outcome, some random noise
    task automatic queue_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) begin
                k = $urandom_range(HOT_COUNT - 1);
                queue_branch(hot_addr[k],
                             ($urandom_range(99) < 85) ? hot_bias[k] : !hot_bias[k]);
            end else begin
                queue_branch($urandom, 1'($urandom_range(1)));
            end
        end
    endtask

    // Hold off until every branch is in and every report is back
    task automatic drain();
        while (n_in != n_queued || predictions_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_phase(input logic [1:0] m, input logic en);
        cfg_write(hbp_pkg::CFG_MODE, m);
        cfg_write(hbp_pkg::CFG_BTB_ENABLE, {1'b0, en});
    endtask

    // Sequence the phases
    initial begin
        int set_no;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        br_if.valid   = 1'b0;
        br_if.address = '0;
        br_if.taken   = 1'b0;
        res_if.ready  = 1'b0;
        in_took       = 1'b0;
        rst_done      = 1'b0;
        rx_hold       = 0;
        rx_hold_used  = 1'b0;
        n_queued      = 0;
        n_in          = 0;
        n_checked     = 0;
        n_hits        = 0;
        n_misp        = 0;
        n_err         = 0;
        cycles        = 0;

        // Predictor reset state
        foreach (bim_ctr[i]) bim_ctr[i] = hbp_pkg::BIM_RESET;
        foreach (gsh_ctr[i]) gsh_ctr[i] = hbp_pkg::GSH_RESET;
        foreach (cho_ctr[i]) cho_ctr[i] = hbp_pkg::CHO_RESET;
        for (int s = 0; s < hbp_pkg::BTB_SETS; s++) begin
            for (int w = 0; w < hbp_pkg::BTB_WAYS; w++) begin
                tgt_valid[s][w] = 1'b0;
                tgt_tag[s][w]   = '0;
                tgt_age[s][w]   = hbp_pkg::AGE_W'(w);
            end
        end
        ghist      = '0;
        n_branches = '0;
        n_misses   = '0;
        cur_mode   = hbp_pkg::MODE_BIMODAL;
        btb_on     = 1'b1;

        // Hot branches: several tags crowd each of six sets to force evictions
        for (int i = 0; i < HOT_COUNT; i++) begin
            set_no      = $urandom_range(5) * 7 + 3;
            hot_addr[i] = ($urandom << (hbp_pkg::SET_BITS + 2)) | (32'(set_no) << 2) |
                          32'($urandom_range(3));
            hot_bias[i] = 1'($urandom_range(1));
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        // Bimodal with buffer: address extremes, low bits ignored, fill and evict a set
        set_phase(hbp_pkg::MODE_BIMODAL, 1'b1);
        queue_branch(32'h0000_0000, 1'b0);
        queue_branch(32'hFFFF_FFFF, 1'b1);
        queue_branch(32'hFFFF_FFFF, 1'b1);
        queue_branch(32'hFFFF_FFFC, 1'b0);
        for (int t = 1; t <= hbp_pkg::BTB_WAYS + 1; t++) begin
            queue_branch((32'(t) << (hbp_pkg::SET_BITS + 2)) | (32'd5 << 2),
                         1'($urandom_range(1)));
        end
        queue_branch((32'd1 << (hbp_pkg::SET_BITS + 2)) | (32'd5 << 2), 1'b1);
        queue_branch((32'd5 << (hbp_pkg::SET_BITS + 2)) | (32'd5 << 2), 1'b0);
        queue_random(80);
        drain();

        // Gshare with buffer: a run of taken branches builds the history
        set_phase(hbp_pkg::MODE_GSHARE, 1'b1);
        repeat (3) queue_branch(32'h0000_0040, 1'b1);
        queue_random(70);
        drain();

        // Hybrid with buffer: alternating outcomes move the chooser
        set_phase(hbp_pkg::MODE_HYBRID, 1'b1);
        queue_branch(32'h0000_1230, 1'b1);
        queue_branch(32'h0000_1230, 1'b1);
        queue_branch(32'h0000_1230, 1'b0);
        queue_branch(32'h0000_1230, 1'b1);
        queue_branch(32'h0000_1230, 1'b0);
        queue_random(80);
        drain();

        // Spare mode code with the buffer off
        set_phase(MODE_SPARE, 1'b0);
        queue_branch(32'hFFFF_FFFF, 1'b0);
        queue_branch(32'h0000_0000, 1'b1);
        queue_random(60);
        drain();

        set_phase(hbp_pkg::MODE_GSHARE, 1'b0);
        queue_random(50);
        drain();

        set_phase(hbp_pkg::MODE_HYBRID, 1'b1);
        queue_random(60);
        drain();

        $display("Checked %0d branch reports across bimodal, gshare, hybrid and spare modes,",
                 n_checked);
        $display("target buffer on and off: %0d buffer hits, %0d mispredictions",
                 n_hits, n_misp);
        if (n_err == 0) begin
            $display("hybrid_branch_predictor_btb_core verification clean");
        end else begin
            $display("hybrid_branch_predictor_btb_core verification failed");
        end
        $finish;
    end

endmodule
